>>> rtl/sdq_pkg.sv
// ----------------------------------------------------------------------------
// sdq_pkg - shadow decal quad generator package
// Shared types, state codes, constants and the output formatting function.
// ----------------------------------------------------------------------------
package sdq_pkg;

    localparam int MAX_QUADS = 64;
    localparam int QCNT_W    = 7;
    localparam int SLOT_W    = 8;
    localparam int THR_W     = 15;
    localparam int S_W       = 21;
    localparam int C_W       = 33;
    localparam int V_W       = 40;
    localparam int NORM_W    = 16;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 15;

    localparam logic [THR_W-1:0] THR_RESET = 15'd15565;
    localparam logic [4:0]       SIZE_MUL  = 5'd20;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [1:0] CORNER_A = 2'd0;
    localparam logic [1:0] CORNER_B = 2'd1;
    localparam logic [1:0] CORNER_C = 2'd2;
    localparam logic [1:0] CORNER_D = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_SQ,
        ST_SQRT,
        ST_DIVI,
        ST_DIV,
        ST_MUL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic signed [C_W-1:0] mul_a;
        logic signed [C_W-1:0] mul_b;
        logic [63:0]           sub_a;
        logic [63:0]           sub_b;
    } t_alu_req;

    typedef struct packed {
        logic signed [2*C_W-1:0] prod;
        logic [63:0]             diff;
        logic                    ge;
    } t_alu_rsp;

    // Q.22 to integer, truncated toward zero, saturated to int16
    function automatic logic signed [15:0] f_to_out(input logic signed [V_W-1:0] v);
        logic signed [17:0] q;
        q = v[V_W-1:22];
        if (v[V_W-1] && (v[21:0] != 22'd0)) q = q + 18'sd1;
        if (q > 18'sd32767) return 16'sh7FFF;
        else if (q < -18'sd32768) return 16'sh8000;
        else return q[15:0];
    endfunction

endpackage

>>> rtl/sdq_in_if.sv
// ----------------------------------------------------------------------------
// sdq_in_if - decal request channel
// Valid/ready channel carrying one add or clear word.
// ----------------------------------------------------------------------------
interface sdq_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [15:0]        extent;

    modport source (output valid, operation, pos_x, pos_y, pos_z,
                    norm_x, norm_y, norm_z, extent, input ready);
    modport sink   (input valid, operation, pos_x, pos_y, pos_z,
                    norm_x, norm_y, norm_z, extent, output ready);
endinterface

>>> rtl/sdq_out_if.sv
// ----------------------------------------------------------------------------
// sdq_out_if - decal vertex channel
// Valid/ready channel carrying one corner vertex word.
// ----------------------------------------------------------------------------
interface sdq_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         corner;
    logic [7:0]         vertex_slot;
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic signed [15:0] vert_z;
    logic               last;

    modport source (output valid, corner, vertex_slot, vert_x, vert_y, vert_z, last,
                    input ready);
    modport sink   (input valid, corner, vertex_slot, vert_x, vert_y, vert_z, last,
                    output ready);
endinterface

>>> rtl/shadow_decal_quad_generator.sv
// ----------------------------------------------------------------------------
// shadow_decal_quad_generator - surface-aligned shadow decal corners
// A clear or full-buffer add is handled in idle. A flat add goes straight to
// corner output; a sloped add first runs two 32-step roots and six 15-step
// divides on the shared unit. A new add is taken only in idle, once the last
// corner of the previous add has been loaded into the output register.
// Reset: counters clear and flat_threshold returns to 15565; no pending words.
// ----------------------------------------------------------------------------
module shadow_decal_quad_generator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [sdq_pkg::THR_W-1:0] i_cfg_wdata,
    sdq_in_if.sink                    i_item,
    sdq_out_if.source                 o_vert
);

    logic [sdq_pkg::THR_W-1:0] r_thr;
    sdq_pkg::t_alu_req         alu_req;
    sdq_pkg::t_alu_rsp         alu_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= sdq_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    sdq_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    sdq_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_thr   (r_thr),
        .i_item  (i_item),
        .o_vert  (o_vert),
        .o_req   (alu_req),
        .i_rsp   (alu_rsp)
    );

endmodule

>>> rtl/sdq_alu.sv
// ----------------------------------------------------------------------------
// sdq_alu - shared arithmetic unit
// One signed multiplier and one 64-bit subtract/compare, used by the sequencer.
// ----------------------------------------------------------------------------
module sdq_alu (
    input  sdq_pkg::t_alu_req i_req,
    output sdq_pkg::t_alu_rsp o_rsp
);

    assign o_rsp.prod = i_req.mul_a * i_req.mul_b;
    assign o_rsp.diff = i_req.sub_a - i_req.sub_b;
    assign o_rsp.ge   = (i_req.sub_a >= i_req.sub_b);

endmodule

>>> rtl/sdq_seq.sv
// ----------------------------------------------------------------------------
// sdq_seq - decal sequencer
// Sloped adds step the shared unit through products, two normalisations and
// corner offsets; all adds emit four vertex words through the output register.
// ----------------------------------------------------------------------------
module sdq_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [sdq_pkg::THR_W-1:0]   i_thr,
    sdq_in_if.sink                      i_item,
    sdq_out_if.source                   o_vert,
    output sdq_pkg::t_alu_req           o_req,
    input  sdq_pkg::t_alu_rsp           i_rsp
);

    localparam int C_W = sdq_pkg::C_W;
    localparam int V_W = sdq_pkg::V_W;
    localparam int N_W = sdq_pkg::NORM_W;

    sdq_pkg::t_state r_state, n_state;

    logic [4:0]                    r_step, n_step;
    logic [1:0]                    r_idx, n_idx;
    logic                          r_vec, n_vec;
    logic [1:0]                    r_corner, n_corner;
    logic [sdq_pkg::QCNT_W-1:0]    r_quads, n_quads;
    logic [sdq_pkg::SLOT_W-1:0]    r_next, n_next;
    logic                          r_ov, n_ov;

    logic [sdq_pkg::SLOT_W-1:0]    r_base, n_base;
    logic signed [15:0]            r_px, r_py, r_pz, r_nx, r_ny, r_nz;
    logic signed [15:0]            n_px, n_py, n_pz, n_nx, n_ny, n_nz;
    logic [sdq_pkg::S_W-1:0]       r_s, n_s;
    logic                          r_flat, n_flat;
    logic signed [C_W-1:0]         r_rc [0:2];
    logic signed [C_W-1:0]         n_rc [0:2];
    logic signed [C_W-1:0]         r_uc [0:2];
    logic signed [C_W-1:0]         n_uc [0:2];
    logic [63:0]                   r_acc, n_acc;
    logic [63:0]                   r_root, n_root;
    logic [63:0]                   r_bit, n_bit;
    logic [63:0]                   r_dsr, n_dsr;
    logic [13:0]                   r_q, n_q;
    logic signed [N_W-1:0]         r_rn [0:2];
    logic signed [N_W-1:0]         n_rn [0:2];
    logic signed [N_W-1:0]         r_un [0:2];
    logic signed [N_W-1:0]         n_un [0:2];
    logic signed [V_W-1:0]         r_va [0:2];
    logic signed [V_W-1:0]         n_va [0:2];
    logic signed [V_W-1:0]         r_vb [0:2];
    logic signed [V_W-1:0]         n_vb [0:2];

    logic [1:0]                    r_oc, n_oc;
    logic [sdq_pkg::SLOT_W-1:0]    r_oslot, n_oslot;
    logic signed [15:0]            r_ox, r_oy, r_oz, n_ox, n_oy, n_oz;
    logic                          r_olast, n_olast;

    logic                          acc_in;
    logic                          load;
    logic                          flat_in;
    logic signed [C_W-1:0]         c_cur;
    logic [C_W-1:0]                c_mag;
    logic [14:0]                   q_fin;
    logic signed [N_W-1:0]         norm;
    logic signed [16:0]            mul_op;
    logic signed [V_W-1:0]         cen_x, cen_y, cen_z;
    logic signed [V_W-1:0]         d_x, d_y, d_z;
    logic signed [V_W-1:0]         size22;

    assign acc_in  = i_item.valid && i_item.ready;
    assign load    = (r_state == sdq_pkg::ST_EMIT) && (!r_ov || o_vert.ready);
    assign flat_in = $signed({i_item.norm_y[15], i_item.norm_y}) >
                     $signed({2'b00, i_thr});
    assign c_cur   = r_vec ? r_uc[r_idx] : r_rc[r_idx];
    assign c_mag   = c_cur[C_W-1] ? C_W'(-c_cur) : C_W'(c_cur);
    assign q_fin   = {r_q, i_rsp.ge};
    assign norm    = (r_root == 64'd0) ? '0 :
                     (c_cur[C_W-1] ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin}));
    assign mul_op  = r_step[0] ? (17'(r_rn[r_idx]) + 17'(r_un[r_idx]))
                               : (17'(r_rn[r_idx]) - 17'(r_un[r_idx]));
    assign size22  = $signed({19'd0, r_s}) <<< 14;

    assign cen_x = ($signed(V_W'(r_px)) <<< 20) + (r_flat ? '0 : ($signed(V_W'(r_nx)) <<< 10));
    assign cen_y = ($signed(V_W'(r_py)) <<< 20) + ($signed(V_W'(r_ny)) <<< 10);
    assign cen_z = ($signed(V_W'(r_pz)) <<< 20) + (r_flat ? '0 : ($signed(V_W'(r_nz)) <<< 10));

    assign i_item.ready       = (r_state == sdq_pkg::ST_IDLE);
    assign o_vert.valid       = r_ov;
    assign o_vert.corner      = r_oc;
    assign o_vert.vertex_slot = r_oslot;
    assign o_vert.vert_x      = r_ox;
    assign o_vert.vert_y      = r_oy;
    assign o_vert.vert_z      = r_oz;
    assign o_vert.last        = r_olast;

    // corner offsets
    always_comb begin
        if (r_flat) begin
            d_x = (r_corner == sdq_pkg::CORNER_A || r_corner == sdq_pkg::CORNER_D)
                  ? -size22 : size22;
            d_y = '0;
            d_z = (r_corner == sdq_pkg::CORNER_A || r_corner == sdq_pkg::CORNER_B)
                  ? -size22 : size22;
        end else begin
            case (r_corner)
                sdq_pkg::CORNER_A: begin
                    d_x = -r_va[0]; d_y = -r_va[1]; d_z = -r_va[2];
                end
                sdq_pkg::CORNER_B: begin
                    d_x = r_va[0]; d_y = r_va[1]; d_z = r_va[2];
                end
                sdq_pkg::CORNER_C: begin
                    d_x = r_vb[0]; d_y = r_vb[1]; d_z = r_vb[2];
                end
                default: begin
                    d_x = -r_vb[0]; d_y = -r_vb[1]; d_z = -r_vb[2];
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sdq_pkg::ST_IDLE: begin
                if (acc_in && i_item.operation == sdq_pkg::OP_ADD &&
                    r_quads < sdq_pkg::QCNT_W'(sdq_pkg::MAX_QUADS)) begin
                    n_state = flat_in ? sdq_pkg::ST_EMIT : sdq_pkg::ST_PROD;
                end
            end
            sdq_pkg::ST_PROD: begin
                if (r_step[1:0] == 2'd3) n_state = sdq_pkg::ST_SQ;
            end
            sdq_pkg::ST_SQ: begin
                if (r_idx == 2'd2) n_state = sdq_pkg::ST_SQRT;
            end
            sdq_pkg::ST_SQRT: begin
                if (r_step == 5'(sdq_pkg::SQRT_STEPS - 1)) n_state = sdq_pkg::ST_DIVI;
            end
            sdq_pkg::ST_DIVI: n_state = sdq_pkg::ST_DIV;
            sdq_pkg::ST_DIV: begin
                if (r_step == 5'(sdq_pkg::DIV_STEPS - 1)) begin
                    if (r_idx != 2'd2) n_state = sdq_pkg::ST_DIVI;
                    else if (!r_vec)   n_state = sdq_pkg::ST_SQ;
                    else               n_state = sdq_pkg::ST_MUL;
                end
            end
            sdq_pkg::ST_MUL: begin
                if (r_idx == 2'd2 && r_step[0]) n_state = sdq_pkg::ST_EMIT;
            end
            sdq_pkg::ST_EMIT: begin
                if (load && r_corner == sdq_pkg::CORNER_D) n_state = sdq_pkg::ST_IDLE;
            end
            default: n_state = sdq_pkg::ST_IDLE;
        endcase
    end

    // datapath and shared unit requests
    always_comb begin
        n_step = r_step; n_idx = r_idx; n_vec = r_vec; n_corner = r_corner;
        n_quads = r_quads; n_next = r_next; n_base = r_base;
        n_px = r_px; n_py = r_py; n_pz = r_pz; n_nx = r_nx; n_ny = r_ny; n_nz = r_nz;
        n_s = r_s; n_flat = r_flat;
        n_rc = r_rc; n_uc = r_uc; n_rn = r_rn; n_un = r_un; n_va = r_va; n_vb = r_vb;
        n_acc = r_acc; n_root = r_root; n_bit = r_bit; n_dsr = r_dsr; n_q = r_q;
        n_oc = r_oc; n_oslot = r_oslot; n_ox = r_ox; n_oy = r_oy; n_oz = r_oz;
        n_olast = r_olast;
        n_ov = r_ov && !o_vert.ready;
        o_req.mul_a = '0;
        o_req.mul_b = '0;
        o_req.sub_a = r_acc;
        o_req.sub_b = r_root + r_bit;

        case (r_state)
            sdq_pkg::ST_IDLE: begin
                if (acc_in) begin
                    if (i_item.operation == sdq_pkg::OP_CLEAR) begin
                        n_quads = '0;
                        n_next  = '0;
                    end else if (r_quads < sdq_pkg::QCNT_W'(sdq_pkg::MAX_QUADS)) begin
                        n_quads  = r_quads + 1'b1;
                        n_next   = r_next + sdq_pkg::SLOT_W'(4);
                        n_base   = r_next;
                        n_px = i_item.pos_x; n_py = i_item.pos_y; n_pz = i_item.pos_z;
                        n_nx = i_item.norm_x; n_ny = i_item.norm_y; n_nz = i_item.norm_z;
                        n_s      = sdq_pkg::S_W'(i_item.extent) *
                                   sdq_pkg::S_W'(sdq_pkg::SIZE_MUL);
                        n_flat   = flat_in;
                        n_rc[0]  = -C_W'(i_item.norm_z);
                        n_rc[1]  = '0;
                        n_rc[2]  = C_W'(i_item.norm_x);
                        n_step   = '0;
                        n_idx    = '0;
                        n_vec    = 1'b0;
                        n_corner = sdq_pkg::CORNER_A;
                        n_acc    = '0;
                    end
                end
            end
            sdq_pkg::ST_PROD: begin
                case (r_step[1:0])
                    2'd0: begin
                        o_req.mul_a = C_W'(r_nx); o_req.mul_b = C_W'(r_ny);
                        n_uc[0] = -i_rsp.prod[C_W-1:0];
                    end
                    2'd1: begin
                        o_req.mul_a = C_W'(r_nx); o_req.mul_b = C_W'(r_nx);
                        n_uc[1] = i_rsp.prod[C_W-1:0];
                    end
                    2'd2: begin
                        o_req.mul_a = C_W'(r_nz); o_req.mul_b = C_W'(r_nz);
                        n_uc[1] = r_uc[1] + i_rsp.prod[C_W-1:0];
                    end
                    default: begin
                        o_req.mul_a = C_W'(r_nz); o_req.mul_b = C_W'(r_ny);
                        n_uc[2] = -i_rsp.prod[C_W-1:0];
                    end
                endcase
                n_step = r_step + 1'b1;
                if (r_step[1:0] == 2'd3) begin
                    n_step = '0;
                    n_idx  = '0;
                    n_acc  = '0;
                end
            end
            sdq_pkg::ST_SQ: begin
                o_req.mul_a = c_cur;
                o_req.mul_b = c_cur;
                n_acc = r_acc + i_rsp.prod[63:0];
                n_idx = r_idx + 1'b1;
                if (r_idx == 2'd2) begin
                    n_idx  = '0;
                    n_step = '0;
                    n_root = '0;
                    n_bit  = 64'd1 << 62;
                end
            end
            sdq_pkg::ST_SQRT: begin
                if (i_rsp.ge) begin
                    n_acc  = i_rsp.diff;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit  = r_bit >> 2;
                n_step = r_step + 1'b1;
            end
            sdq_pkg::ST_DIVI: begin
                n_acc  = 64'(c_mag) << 14;
                n_dsr  = r_root << 14;
                n_q    = '0;
                n_step = '0;
            end
            sdq_pkg::ST_DIV: begin
                o_req.sub_a = r_acc;
                o_req.sub_b = r_dsr;
                if (i_rsp.ge) n_acc = i_rsp.diff;
                n_q    = q_fin[13:0];
                n_dsr  = r_dsr >> 1;
                n_step = r_step + 1'b1;
                if (r_step == 5'(sdq_pkg::DIV_STEPS - 1)) begin
                    if (r_vec) n_un[r_idx] = norm;
                    else       n_rn[r_idx] = norm;
                    n_step = '0;
                    if (r_idx != 2'd2) begin
                        n_idx = r_idx + 1'b1;
                    end else begin
                        n_idx = '0;
                        n_vec = 1'b1;
                        n_acc = '0;
                    end
                end
            end
            sdq_pkg::ST_MUL: begin
                o_req.mul_a = C_W'(mul_op);
                o_req.mul_b = $signed({12'd0, r_s});
                if (r_step[0]) n_vb[r_idx] = i_rsp.prod[V_W-1:0];
                else           n_va[r_idx] = i_rsp.prod[V_W-1:0];
                n_step = {4'd0, ~r_step[0]};
                if (r_step[0]) n_idx = r_idx + 1'b1;
                if (r_step[0] && r_idx == 2'd2) begin
                    n_idx    = '0;
                    n_corner = sdq_pkg::CORNER_A;
                end
            end
            sdq_pkg::ST_EMIT: begin
                if (load) begin
                    n_ov     = 1'b1;
                    n_oc     = r_corner;
                    n_oslot  = r_base + sdq_pkg::SLOT_W'(r_corner);
                    n_ox     = sdq_pkg::f_to_out(cen_x + d_x);
                    n_oy     = sdq_pkg::f_to_out(cen_y + d_y);
                    n_oz     = sdq_pkg::f_to_out(cen_z + d_z);
                    n_olast  = (r_corner == sdq_pkg::CORNER_D);
                    n_corner = r_corner + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sdq_pkg::ST_IDLE;
            r_step   <= '0;
            r_idx    <= '0;
            r_vec    <= 1'b0;
            r_corner <= sdq_pkg::CORNER_A;
            r_quads  <= '0;
            r_next   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_idx    <= n_idx;
            r_vec    <= n_vec;
            r_corner <= n_corner;
            r_quads  <= n_quads;
            r_next   <= n_next;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_px <= n_px; r_py <= n_py; r_pz <= n_pz;
        r_nx <= n_nx; r_ny <= n_ny; r_nz <= n_nz;
        r_s <= n_s; r_flat <= n_flat;
        r_rc <= n_rc; r_uc <= n_uc; r_rn <= n_rn; r_un <= n_un;
        r_va <= n_va; r_vb <= n_vb;
        r_acc <= n_acc; r_root <= n_root; r_bit <= n_bit; r_dsr <= n_dsr; r_q <= n_q;
        r_oc <= n_oc; r_oslot <= n_oslot;
        r_ox <= n_ox; r_oy <= n_oy; r_oz <= n_oz; r_olast <= n_olast;
    end

endmodule
